// ----- rtl/olist_pkg.sv -----
// Shared types and codes for the ordered list engine.
`default_nettype none

package olist_pkg;

   localparam int DATA_W  = 32;
   localparam int OP_W    = 3;
   localparam int STAT_W  = 2;
   localparam int COUNT_W = 5;

   // Operation codes carried by an input beat.
   typedef enum logic [OP_W-1:0] {
      OP_PREPEND    = 3'd0,
      OP_APPEND     = 3'd1,
      OP_INS_BEFORE = 3'd2,
      OP_INS_AFTER  = 3'd3,
      OP_DEL_FRONT  = 3'd4,
      OP_DEL_LAST   = 3'd5,
      OP_DEL_VALUE  = 3'd6,
      OP_READ_ALL   = 3'd7
   } op_type;

   // Status codes carried by a result beat.
   typedef enum logic [STAT_W-1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_EMPTY   = 2'd2,
      ST_MISSING = 2'd3
   } status_type;

   // Sequencer states, one-hot.
   typedef enum logic [8:0] {
      S_IDLE     = 9'b000000001,
      S_SRCH_RD  = 9'b000000010,
      S_SRCH_CMP = 9'b000000100,
      S_SHUP_RD  = 9'b000001000,
      S_SHUP_WR  = 9'b000010000,
      S_SHDN_RD  = 9'b000100000,
      S_SHDN_WR  = 9'b001000000,
      S_DUMP_RD  = 9'b010000000,
      S_DUMP_OUT = 9'b100000000
   } state_type;

endpackage

`default_nettype wire

// ----- rtl/olist_mem.sv -----
// Entry storage: one write port and one read port with registered read data.
`default_nettype none

module olist_mem #(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  wire logic                               clock,
   input  wire logic                               wr_en,
   input  wire logic [ADDR_W-1:0]                  wr_addr,
   input  wire logic signed [olist_pkg::DATA_W-1:0] wr_data,
   input  wire logic                               rd_en,
   input  wire logic [ADDR_W-1:0]                  rd_addr,
   output logic signed [olist_pkg::DATA_W-1:0]      rd_data_ff
);

   logic signed [olist_pkg::DATA_W-1:0] mem_ff [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, data appears the cycle after the address.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/ordered_list_engine.sv -----
// Ordered list engine: a sequencer walking one memory with one shared compare.
// Delete last and a full or empty refusal need no walk; their result beat is registered.
// A key search, found or not, reads and then compares each entry visited, and moving
// entries to open or close a slot reads then writes each one, through one memory port.
// Read all gives one result beat per entry; the receiver cannot stall a beat.
// Busy stays high until the final beat is issued. Synchronous reset empties the list.
`default_nettype none

module ordered_list_engine #(
   parameter int CAPACITY = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic [olist_pkg::OP_W-1:0]          req_op,
   input  wire logic signed [olist_pkg::DATA_W-1:0] req_value,
   input  wire logic signed [olist_pkg::DATA_W-1:0] req_key,
   output logic                                     rsp_valid,
   output logic [olist_pkg::STAT_W-1:0]             rsp_status,
   output logic signed [olist_pkg::DATA_W-1:0]      rsp_data,
   output logic [olist_pkg::COUNT_W-1:0]            rsp_count,
   output logic                                     rsp_last
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int EXT_W = (CNT_W > olist_pkg::COUNT_W) ? CNT_W : olist_pkg::COUNT_W;
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
   localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

   olist_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     ptr_ff, ptr_in;
   logic [CNT_W-1:0]     pos_ff, pos_in;
   olist_pkg::op_type    op_ff, op_in;
   logic signed [olist_pkg::DATA_W-1:0] value_ff, value_in;
   logic signed [olist_pkg::DATA_W-1:0] key_ff, key_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   olist_pkg::status_type         rsp_status_ff, rsp_status_in;
   logic signed [olist_pkg::DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [olist_pkg::COUNT_W-1:0] rsp_count_ff;
   logic                          rsp_last_ff, rsp_last_in;

   logic                          wr_en;
   logic [IDX_W-1:0]              wr_addr;
   logic signed [olist_pkg::DATA_W-1:0] wr_data;
   logic                          rd_en;
   logic [IDX_W-1:0]              rd_addr;
   logic signed [olist_pkg::DATA_W-1:0] rd_data;

   logic [CNT_W-1:0]              ptr_plus;
   logic                          key_hit;
   logic                          accept;
   logic [EXT_W-1:0]              count_ext;

   assign accept   = start && (state_ff == olist_pkg::S_IDLE);
   assign ptr_plus = ptr_ff + ONE_CNT;
   // The shared compare unit checks the fetched entry against the key.
   assign key_hit  = (rd_data == key_ff);

   olist_mem #(
      .DEPTH  (CAPACITY),
      .ADDR_W (IDX_W)
   ) u_mem (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   // Sequencer next-state and memory control.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      pos_in        = pos_ff;
      op_in         = op_ff;
      value_in      = value_ff;
      key_in        = key_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = olist_pkg::ST_OK;
      rsp_data_in   = '0;
      rsp_last_in   = 1'b1;
      wr_en         = 1'b0;
      wr_addr       = ptr_ff[IDX_W-1:0];
      wr_data       = rd_data;
      rd_en         = 1'b0;
      rd_addr       = ptr_ff[IDX_W-1:0];

      case (state_ff)
         olist_pkg::S_IDLE: begin
            if (accept) begin
               op_in    = olist_pkg::op_type'(req_op);
               value_in = req_value;
               key_in   = req_key;
               if (op_in == olist_pkg::OP_READ_ALL) begin
                  if (count_ff == '0) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = olist_pkg::ST_EMPTY;
                  end else begin
                     ptr_in   = '0;
                     state_in = olist_pkg::S_DUMP_RD;
                  end
               end else if (op_in inside {olist_pkg::OP_PREPEND, olist_pkg::OP_APPEND,
                                          olist_pkg::OP_INS_BEFORE, olist_pkg::OP_INS_AFTER}
                            && count_ff == CAP_CNT) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = olist_pkg::ST_FULL;
               end else if (!(op_in inside {olist_pkg::OP_PREPEND, olist_pkg::OP_APPEND})
                            && count_ff == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = olist_pkg::ST_EMPTY;
               end else begin
                  case (op_in)
                     olist_pkg::OP_PREPEND: begin
                        pos_in   = '0;
                        ptr_in   = count_ff;
                        state_in = olist_pkg::S_SHUP_RD;
                     end
                     olist_pkg::OP_APPEND: begin
                        pos_in   = count_ff;
                        ptr_in   = count_ff;
                        state_in = olist_pkg::S_SHUP_RD;
                     end
                     olist_pkg::OP_DEL_FRONT: begin
                        ptr_in   = '0;
                        state_in = olist_pkg::S_SHDN_RD;
                     end
                     olist_pkg::OP_DEL_LAST: begin
                        count_in     = count_ff - ONE_CNT;
                        rsp_valid_in = 1'b1;
                     end
                     default: begin
                        ptr_in   = '0;
                        state_in = olist_pkg::S_SRCH_RD;
                     end
                  endcase
               end
            end
         end

         // Key search: fetch one entry, then compare it.
         olist_pkg::S_SRCH_RD: begin
            if (ptr_ff == count_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = olist_pkg::ST_MISSING;
               state_in      = olist_pkg::S_IDLE;
            end else begin
               rd_en    = 1'b1;
               state_in = olist_pkg::S_SRCH_CMP;
            end
         end

         olist_pkg::S_SRCH_CMP: begin
            if (key_hit) begin
               if (op_ff == olist_pkg::OP_DEL_VALUE) begin
                  state_in = olist_pkg::S_SHDN_RD;
               end else begin
                  pos_in   = (op_ff == olist_pkg::OP_INS_BEFORE) ? ptr_ff : ptr_plus;
                  ptr_in   = count_ff;
                  state_in = olist_pkg::S_SHUP_RD;
               end
            end else begin
               ptr_in   = ptr_plus;
               state_in = olist_pkg::S_SRCH_RD;
            end
         end

         // Open a slot at pos by moving entries up from the back, then fill it.
         olist_pkg::S_SHUP_RD: begin
            if (ptr_ff == pos_ff) begin
               wr_en        = 1'b1;
               wr_addr      = pos_ff[IDX_W-1:0];
               wr_data      = value_ff;
               count_in     = count_ff + ONE_CNT;
               rsp_valid_in = 1'b1;
               state_in     = olist_pkg::S_IDLE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = IDX_W'(ptr_ff - ONE_CNT);
               state_in = olist_pkg::S_SHUP_WR;
            end
         end

         olist_pkg::S_SHUP_WR: begin
            wr_en    = 1'b1;
            ptr_in   = ptr_ff - ONE_CNT;
            state_in = olist_pkg::S_SHUP_RD;
         end

         // Close the slot at ptr by moving later entries down one place.
         olist_pkg::S_SHDN_RD: begin
            if (ptr_plus >= count_ff) begin
               count_in     = count_ff - ONE_CNT;
               rsp_valid_in = 1'b1;
               state_in     = olist_pkg::S_IDLE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = ptr_plus[IDX_W-1:0];
               state_in = olist_pkg::S_SHDN_WR;
            end
         end

         olist_pkg::S_SHDN_WR: begin
            wr_en    = 1'b1;
            ptr_in   = ptr_plus;
            state_in = olist_pkg::S_SHDN_RD;
         end

         // Read all: one result beat per entry, front to back.
         olist_pkg::S_DUMP_RD: begin
            rd_en    = 1'b1;
            state_in = olist_pkg::S_DUMP_OUT;
         end

         olist_pkg::S_DUMP_OUT: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = rd_data;
            rsp_last_in  = (ptr_plus == count_ff);
            ptr_in       = ptr_plus;
            state_in     = rsp_last_in ? olist_pkg::S_IDLE : olist_pkg::S_DUMP_RD;
         end

         default: begin
            state_in = olist_pkg::S_IDLE;
         end
      endcase
   end

   assign count_ext = EXT_W'(count_in);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= olist_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      ptr_ff        <= ptr_in;
      pos_ff        <= pos_in;
      op_ff         <= op_in;
      value_ff      <= value_in;
      key_ff        <= key_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_count_ff  <= count_ext[olist_pkg::COUNT_W-1:0];
      rsp_last_ff   <= rsp_last_in;
   end

   assign busy       = (state_ff != olist_pkg::S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_count  = rsp_count_ff;
   assign rsp_last   = rsp_last_ff;

`ifndef ASSERT_OFF
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_CNT)
      else $error("entry count exceeds capacity");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> !busy)
      else $error("final result issued while sequencer still busy");

   a_more_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> busy)
      else $error("non-final result with sequencer idle");

   a_fail_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status_ff != olist_pkg::ST_OK |-> $stable(count_ff))
      else $error("refused operation changed the entry count");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status_ff == olist_pkg::ST_EMPTY |-> count_ff == '0)
      else $error("empty status with entries present");
`endif

endmodule

`default_nettype wire
